// ----- hdl/afs_pkg.sv -----
package afs_pkg;

   localparam int COUNT_WIDTH    = 24;
   localparam int POSITION_WIDTH = 32;
   localparam int OFFSET_WIDTH   = 29;
   localparam int FLEN_WIDTH     = 13;
   localparam int RATE_WIDTH     = 17;
   localparam int TOTAL_WIDTH    = COUNT_WIDTH + FLEN_WIDTH;
   localparam int THRESH_WIDTH   = COUNT_WIDTH + RATE_WIDTH;
   localparam int NUM_WIDTH      = TOTAL_WIDTH;
   localparam int DEN_WIDTH      = (COUNT_WIDTH > RATE_WIDTH) ? COUNT_WIDTH : RATE_WIDTH;
   localparam int DIV_CNT_WIDTH  = $clog2(NUM_WIDTH + 1);
   localparam int FRAME_SAMPLES_LOG2 = 10;

   localparam logic [3:0]  HEADER_LAST   = 4'd9;
   localparam logic [12:0] HEADER_BYTES  = 13'd10;
   localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
   localparam logic [7:0]  SYNC_MASK     = 8'hF6;
   localparam logic [7:0]  SYNC_VALUE    = 8'hF0;
   localparam logic [3:0]  RATE_INDEX_LIMIT = 4'd12;

   localparam logic [2:0] STATUS_ENDED     = 3'd0;
   localparam logic [2:0] STATUS_SYNC_LOST = 3'd1;
   localparam logic [2:0] STATUS_BAD_RATE  = 3'd2;
   localparam logic [2:0] STATUS_SHORT     = 3'd3;
   localparam logic [2:0] STATUS_NO_FRAME  = 3'd4;

   localparam logic [2:0] VERSION_MPEG2 = 3'd2;
   localparam logic [2:0] VERSION_MPEG4 = 3'd4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_PAYLOAD,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUN,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_BR,
      ST_LEN_GO,
      ST_LEN_WAIT,
      ST_LEN,
      ST_PUT
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic div_start;
      logic div_len;
      logic save_avg;
      logic save_len;
      logic put_sum;
   } afs_cmd_type;

   typedef struct packed {
      logic out_free;
      logic summ;
      logic sum_nz;
      logic div_done;
   } afs_stat_type;

   function automatic logic [RATE_WIDTH-1:0] rate_of(input logic [3:0] idx);
      logic [RATE_WIDTH-1:0] r;
      unique case (idx)
         4'd0:    r = 17'd96000;
         4'd1:    r = 17'd88200;
         4'd2:    r = 17'd64000;
         4'd3:    r = 17'd48000;
         4'd4:    r = 17'd44100;
         4'd5:    r = 17'd32000;
         4'd6:    r = 17'd24000;
         4'd7:    r = 17'd22050;
         4'd8:    r = 17'd16000;
         4'd9:    r = 17'd12000;
         4'd10:   r = 17'd11025;
         default: r = 17'd8000;
      endcase
      return r;
   endfunction

endpackage

// ----- hdl/adts_frame_scanner.sv -----
// Channel   Ports                         Moves
// req       req_valid / req_ready         one stream byte and its last flag
// rsp       rsp_valid / rsp_ready         a seek entry or the closing summary
// csr       csr_write_enable, _data       start offset added to seek positions
//
// Bytes are taken back to back while the output register has room. A header
// that emits a seek entry holds the next byte until the output register has
// room again. The summary runs two 37-step passes of the shared radix-2 divider
// when any frame was counted; no byte is taken until the summary is loaded.
// Reset is synchronous; it clears the scanner state and the start offset.
module adts_frame_scanner import afs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [28:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [23:0] rsp_second_index,
   output logic [31:0] rsp_byte_position,
   output logic [2:0]  rsp_status,
   output logic [23:0] rsp_frame_count,
   output logic [1:0]  rsp_profile,
   output logic [16:0] rsp_sample_rate,
   output logic [2:0]  rsp_channels,
   output logic [2:0]  rsp_version,
   output logic [22:0] rsp_bitrate,
   output logic [31:0] rsp_length_ms
);

   afs_cmd_type  cmd;
   afs_stat_type stat;

   afs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   afs_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_data_byte     (req_data_byte),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_second_index  (rsp_second_index),
      .rsp_byte_position (rsp_byte_position),
      .rsp_status        (rsp_status),
      .rsp_frame_count   (rsp_frame_count),
      .rsp_profile       (rsp_profile),
      .rsp_sample_rate   (rsp_sample_rate),
      .rsp_channels      (rsp_channels),
      .rsp_version       (rsp_version),
      .rsp_bitrate       (rsp_bitrate),
      .rsp_length_ms     (rsp_length_ms)
   );

   a_put_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.put_sum |-> stat.out_free)
      else $error("summary loaded while output register is full");

   a_ready_needs_room: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> stat.out_free)
      else $error("byte taken while output register is full");

   a_div_multicycle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("divider finished in one cycle");

   a_seek_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_kind) |-> (rsp_status == STATUS_ENDED && rsp_frame_count == '0))
      else $error("seek entry carries summary fields");

endmodule

// ----- hdl/afs_div.sv -----
module afs_div import afs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [NUM_WIDTH-1:0] dividend,
   input  logic [DEN_WIDTH-1:0] divisor,
   output logic                 done,
   output logic [NUM_WIDTH-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [NUM_WIDTH-1:0]     quo_ff, quo_in;
   logic [DEN_WIDTH-1:0]     rem_ff, rem_in;
   logic [DEN_WIDTH-1:0]     den_ff, den_in;
   logic [DEN_WIDTH:0]       rem_sh, rem_sub;
   logic                     ge;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_WIDTH-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_WIDTH'(NUM_WIDTH);
         quo_in  = dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_WIDTH-2:0], ge};
         rem_in = ge ? rem_sub[DEN_WIDTH-1:0] : rem_sh[DEN_WIDTH-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hdl/afs_dpath.sv -----
module afs_dpath import afs_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  afs_cmd_type             cmd,
   output afs_stat_type            stat,
   input  logic                    csr_write_enable,
   input  logic [OFFSET_WIDTH-1:0] csr_write_data,
   input  logic [7:0]              req_data_byte,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    rsp_kind,
   output logic [23:0]             rsp_second_index,
   output logic [31:0]             rsp_byte_position,
   output logic [2:0]              rsp_status,
   output logic [23:0]             rsp_frame_count,
   output logic [1:0]              rsp_profile,
   output logic [16:0]             rsp_sample_rate,
   output logic [2:0]              rsp_channels,
   output logic [2:0]              rsp_version,
   output logic [22:0]             rsp_bitrate,
   output logic [31:0]             rsp_length_ms
);

   localparam int BR_PROD_WIDTH  = FLEN_WIDTH + RATE_WIDTH;
   localparam int LEN_PROD_WIDTH = NUM_WIDTH + 10;

   logic [OFFSET_WIDTH-1:0]   offset_ff;
   phase_type                 phase_ff, phase_in;
   logic [3:0]                cnt_ff, cnt_in;
   logic [47:0]               hdr_ff, hdr_in;
   logic [FLEN_WIDTH-1:0]     pay_ff, pay_in;
   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [POSITION_WIDTH-1:0] fstart_ff, fstart_in;
   logic [COUNT_WIDTH-1:0]    frames_ff, frames_in;
   logic [TOTAL_WIDTH-1:0]    total_ff, total_in;
   logic [COUNT_WIDTH-1:0]    secs_ff, secs_in;
   logic [THRESH_WIDTH-1:0]   thr_ff, thr_in;
   logic                      fid_ff, fid_in;
   logic [1:0]                fobj_ff, fobj_in;
   logic [3:0]                fidx_ff, fidx_in;
   logic [2:0]                fch_ff, fch_in;

   logic [2:0]                sum_status_ff, sum_status_in;
   logic [COUNT_WIDTH-1:0]    sum_frames_ff, sum_frames_in;
   logic [TOTAL_WIDTH-1:0]    sum_total_ff, sum_total_in;
   logic                      sum_id_ff, sum_id_in;
   logic [1:0]                sum_obj_ff, sum_obj_in;
   logic [3:0]                sum_idx_ff, sum_idx_in;
   logic [2:0]                sum_ch_ff, sum_ch_in;
   logic [22:0]               br_ff;
   logic [31:0]               len_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_kind_ff;
   logic [23:0]               rsp_second_ff;
   logic [31:0]               rsp_pos_ff;
   logic [2:0]                rsp_status_ff;
   logic [23:0]               rsp_frames_ff;
   logic [1:0]                rsp_obj_ff;
   logic [16:0]               rsp_rate_ff;
   logic [2:0]                rsp_ch_ff;
   logic [2:0]                rsp_ver_ff;
   logic [22:0]               rsp_br_ff;
   logic [31:0]               rsp_len_ff;

   logic [7:0]                b0, b1, b2, b3, b4, b5;
   logic                      active, hdr_done, first, sync_ok, bad_idx, short_len;
   logic                      hdr_stop, hdr_ok, seek, summ;
   logic [2:0]                stop_code;
   logic                      id_use;
   logic [FLEN_WIDTH-1:0]     flen;
   logic [RATE_WIDTH-1:0]     sum_rate;
   logic [POSITION_WIDTH-1:0] seek_pos;

   logic                      div_done;
   logic [NUM_WIDTH-1:0]      div_num;
   logic [DEN_WIDTH-1:0]      div_den;
   logic [NUM_WIDTH-1:0]      quo;
   logic [BR_PROD_WIDTH-1:0]  br_prod;
   logic [LEN_PROD_WIDTH-1:0] len_prod;

   assign b0 = hdr_ff[7:0];
   assign b1 = hdr_ff[15:8];
   assign b2 = hdr_ff[23:16];
   assign b3 = hdr_ff[31:24];
   assign b4 = hdr_ff[39:32];
   assign b5 = hdr_ff[47:40];

   always_comb begin
      active    = phase_ff != PH_DONE;
      hdr_done  = active && (phase_ff == PH_HEADER) && (cnt_ff == HEADER_LAST);
      first     = frames_ff == '0;
      sync_ok   = (b0 == SYNC_BYTE) && ((b1 & SYNC_MASK) == SYNC_VALUE);
      bad_idx   = first && (b2[5:2] >= RATE_INDEX_LIMIT);
      id_use    = first ? b1[3] : fid_ff;
      flen      = id_use ? {b3[1:0], b4, b5[7:5]} : {b4, b5[7:3]};
      short_len = flen < HEADER_BYTES;
      priority if (!sync_ok) stop_code = STATUS_SYNC_LOST;
      else if (bad_idx)      stop_code = STATUS_BAD_RATE;
      else                   stop_code = STATUS_SHORT;
      hdr_stop  = hdr_done && (!sync_ok || bad_idx || short_len);
      hdr_ok    = hdr_done && !hdr_stop;
      // A frame is a second past the last seek entry once frames*1024 passes
      // the running sum of rates.
      seek      = hdr_ok &&
                  ((THRESH_WIDTH'(frames_ff) << FRAME_SAMPLES_LOG2) > thr_ff);
      summ      = active && (hdr_stop || req_last);
   end

   always_comb begin
      phase_in      = phase_ff;
      cnt_in        = cnt_ff;
      hdr_in        = hdr_ff;
      pay_in        = pay_ff;
      pos_in        = pos_ff;
      fstart_in     = fstart_ff;
      frames_in     = frames_ff;
      total_in      = total_ff;
      secs_in       = secs_ff;
      thr_in        = thr_ff;
      fid_in        = fid_ff;
      fobj_in       = fobj_ff;
      fidx_in       = fidx_ff;
      fch_in        = fch_ff;
      sum_status_in = sum_status_ff;
      sum_frames_in = sum_frames_ff;
      sum_total_in  = sum_total_ff;
      sum_id_in     = sum_id_ff;
      sum_obj_in    = sum_obj_ff;
      sum_idx_in    = sum_idx_ff;
      sum_ch_in     = sum_ch_ff;
      if (cmd.take) begin
         if (active) begin
            if (phase_ff == PH_PAYLOAD) begin
               pay_in = pay_ff - 1'b1;
               if (pay_ff == FLEN_WIDTH'(1)) phase_in = PH_HEADER;
            end else begin
               if (cnt_ff == '0) fstart_in = pos_ff;
               if (cnt_ff < 4'd6) hdr_in[{cnt_ff[2:0], 3'b000} +: 8] = req_data_byte;
               cnt_in = cnt_ff + 1'b1;
               if (hdr_done) begin
                  cnt_in = '0;
                  hdr_in = '0;
                  if (first && sync_ok && !bad_idx) begin
                     fid_in  = b1[3];
                     fobj_in = b2[7:6];
                     fidx_in = b2[5:2];
                     fch_in  = {b2[0], b3[7:6]};
                  end
                  if (hdr_ok) begin
                     if (seek && (secs_ff != '1)) begin
                        secs_in = secs_ff + 1'b1;
                        thr_in  = thr_ff + THRESH_WIDTH'(rate_of(fidx_ff));
                     end
                     if (frames_ff != '1) begin
                        frames_in = frames_ff + 1'b1;
                        total_in  = total_ff + TOTAL_WIDTH'(flen);
                     end
                     pay_in   = flen - HEADER_BYTES;
                     phase_in = (flen != HEADER_BYTES) ? PH_PAYLOAD : PH_HEADER;
                  end
               end
            end
            pos_in = pos_ff + 1'b1;
            if (summ) begin
               phase_in      = PH_DONE;
               sum_status_in = hdr_stop ? stop_code
                             : ((frames_in != '0) ? STATUS_ENDED : STATUS_NO_FRAME);
               sum_frames_in = frames_in;
               sum_total_in  = total_in;
               sum_id_in     = fid_in;
               sum_obj_in    = fobj_in;
               sum_idx_in    = fidx_in;
               sum_ch_in     = fch_in;
            end
         end
         // The last byte of a file leaves the scanner ready for the next one.
         if (req_last) begin
            phase_in  = PH_HEADER;
            cnt_in    = '0;
            hdr_in    = '0;
            pay_in    = '0;
            pos_in    = '0;
            fstart_in = '0;
            frames_in = '0;
            total_in  = '0;
            secs_in   = '0;
            thr_in    = '0;
            fid_in    = 1'b0;
            fobj_in   = '0;
            fidx_in   = '0;
            fch_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         phase_ff  <= PH_HEADER;
         cnt_ff    <= '0;
         hdr_ff    <= '0;
         pay_ff    <= '0;
         pos_ff    <= '0;
         fstart_ff <= '0;
         frames_ff <= '0;
         total_ff  <= '0;
         secs_ff   <= '0;
         thr_ff    <= '0;
         fid_ff    <= 1'b0;
         fobj_ff   <= '0;
         fidx_ff   <= '0;
         fch_ff    <= '0;
      end else begin
         if (csr_write_enable) offset_ff <= csr_write_data;
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         hdr_ff    <= hdr_in;
         pay_ff    <= pay_in;
         pos_ff    <= pos_in;
         fstart_ff <= fstart_in;
         frames_ff <= frames_in;
         total_ff  <= total_in;
         secs_ff   <= secs_in;
         thr_ff    <= thr_in;
         fid_ff    <= fid_in;
         fobj_ff   <= fobj_in;
         fidx_ff   <= fidx_in;
         fch_ff    <= fch_in;
      end
      sum_status_ff <= sum_status_in;
      sum_frames_ff <= sum_frames_in;
      sum_total_ff  <= sum_total_in;
      sum_id_ff     <= sum_id_in;
      sum_obj_ff    <= sum_obj_in;
      sum_idx_ff    <= sum_idx_in;
      sum_ch_ff     <= sum_ch_in;
   end

   // Summary arithmetic: average frame size, then frames*1024 over rate.
   assign sum_rate = rate_of(sum_idx_ff);
   assign div_num  = cmd.div_len
                   ? (NUM_WIDTH'(sum_frames_ff) << FRAME_SAMPLES_LOG2) : sum_total_ff;
   assign div_den  = cmd.div_len ? DEN_WIDTH'(sum_rate) : DEN_WIDTH'(sum_frames_ff);

   afs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quo)
   );

   assign br_prod  = BR_PROD_WIDTH'(quo[FLEN_WIDTH-1:0]) * BR_PROD_WIDTH'(sum_rate)
                   + BR_PROD_WIDTH'(512);
   assign len_prod = LEN_PROD_WIDTH'(quo) * LEN_PROD_WIDTH'(1000);

   always_ff @(posedge clock) begin
      if (cmd.save_avg) br_ff <= {br_prod[BR_PROD_WIDTH-1:10], 3'b000};
      if (cmd.save_len) begin
         len_ff <= (|len_prod[LEN_PROD_WIDTH-1:32]) ? 32'hFFFF_FFFF : len_prod[31:0];
      end
   end

   assign seek_pos = POSITION_WIDTH'(offset_ff) + fstart_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((cmd.take && seek) || cmd.put_sum) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.take && seek) begin
         rsp_kind_ff   <= 1'b0;
         rsp_second_ff <= 24'(secs_ff);
         rsp_pos_ff    <= 32'(seek_pos);
         rsp_status_ff <= '0;
         rsp_frames_ff <= '0;
         rsp_obj_ff    <= '0;
         rsp_rate_ff   <= '0;
         rsp_ch_ff     <= '0;
         rsp_ver_ff    <= '0;
         rsp_br_ff     <= '0;
         rsp_len_ff    <= '0;
      end else if (cmd.put_sum) begin
         rsp_kind_ff   <= 1'b1;
         rsp_second_ff <= '0;
         rsp_pos_ff    <= '0;
         rsp_status_ff <= sum_status_ff;
         if (sum_frames_ff != '0) begin
            rsp_frames_ff <= 24'(sum_frames_ff);
            rsp_obj_ff    <= sum_obj_ff;
            rsp_rate_ff   <= sum_rate;
            rsp_ch_ff     <= sum_ch_ff;
            rsp_ver_ff    <= sum_id_ff ? VERSION_MPEG2 : VERSION_MPEG4;
            rsp_br_ff     <= br_ff;
            rsp_len_ff    <= len_ff;
         end else begin
            rsp_frames_ff <= '0;
            rsp_obj_ff    <= '0;
            rsp_rate_ff   <= '0;
            rsp_ch_ff     <= '0;
            rsp_ver_ff    <= '0;
            rsp_br_ff     <= '0;
            rsp_len_ff    <= '0;
         end
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign stat.summ     = summ;
   assign stat.sum_nz   = sum_frames_ff != '0;
   assign stat.div_done = div_done;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_second_index  = rsp_second_ff;
   assign rsp_byte_position = rsp_pos_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_frame_count   = rsp_frames_ff;
   assign rsp_profile       = rsp_obj_ff;
   assign rsp_sample_rate   = rsp_rate_ff;
   assign rsp_channels      = rsp_ch_ff;
   assign rsp_version       = rsp_ver_ff;
   assign rsp_bitrate       = rsp_br_ff;
   assign rsp_length_ms     = rsp_len_ff;

endmodule

// ----- hdl/afs_ctrl.sv -----
module afs_ctrl import afs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  afs_stat_type stat,
   output afs_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_RUN:      if (req_valid && stat.out_free && stat.summ) state_in = ST_AVG_GO;
         ST_AVG_GO:   state_in = stat.sum_nz ? ST_AVG_WAIT : ST_PUT;
         ST_AVG_WAIT: if (stat.div_done) state_in = ST_BR;
         ST_BR:       state_in = ST_LEN_GO;
         ST_LEN_GO:   state_in = ST_LEN_WAIT;
         ST_LEN_WAIT: if (stat.div_done) state_in = ST_LEN;
         ST_LEN:      state_in = ST_PUT;
         ST_PUT:      if (stat.out_free) state_in = ST_RUN;
         default:     state_in = ST_RUN;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready = stat.out_free;
            cmd.take  = req_valid && stat.out_free;
         end
         ST_AVG_GO:   cmd.div_start = stat.sum_nz;
         ST_BR:       cmd.save_avg  = 1'b1;
         ST_LEN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_len   = 1'b1;
         end
         ST_LEN:      cmd.save_len  = 1'b1;
         ST_PUT:      cmd.put_sum   = stat.out_free;
         default:     cmd           = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_RUN;
      else       state_ff <= state_in;
   end

endmodule
